// ===== rtl/core/mamm_pkg.sv =====
// Shared constants, codes and types of the matrix add/multiply/min-max unit.
package mamm_pkg;

	// Default sizes
	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	// Field widths
	localparam int ACT_W       = 3;
	localparam int POS_W       = 3;
	localparam int VAL_W       = 16;
	localparam int KIND_W      = 3;
	localparam int RES_W       = 35;
	localparam int SEC_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 4;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 64;

	// Actions carried on the input tuser
	localparam logic [ACT_W-1:0] ACT_LOAD_A = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SUM    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PROD   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MINMAX = 3'd4;

	// Result kinds carried on the output tuser
	localparam logic [KIND_W-1:0] KIND_SUM     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PROD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MM_A    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MM_B    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INVALID = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd3;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/matrix_add_multiply_minmax_unit.sv =====
// A load is written into its store, and the unit stays ready for the next transaction.
// For a product element, one shared multiplier is fed one term per cycle
// through the registered store read, then the read/multiply/accumulate pipe drains.
// A sum element takes one read and one add; min/max reads every element of each matrix.
// Reset (arst_n, asynchronous, active low) sets all dimensions to 1 and idles the sequencer;
// the element stores are not cleared and hold nothing defined until written.
module matrix_add_multiply_minmax_unit #(
	parameter int MAX_DIM    = mamm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mamm_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mamm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mamm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [2:0] row, [5:3] col, [21:6] value, [23:22] zero
	input  logic [mamm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [2:0] action
	input  logic [mamm_pkg::ACT_W-1:0]          s_axis_tuser,
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [2:0] out_row, [5:3] out_col, [40:6] result_value, [56:41] second_value, [63:57] zero
	output logic [mamm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [2:0] kind
	output logic [mamm_pkg::KIND_W-1:0]         m_axis_tuser,
	output logic                                m_axis_tlast
);

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = ELEM_WIDTH;
	localparam int RW    = mamm_pkg::RES_W;
	localparam int PW    = mamm_pkg::POS_W;
	localparam int SW    = mamm_pkg::SEC_W;
	localparam int CW    = mamm_pkg::CFG_DATA_W;

	// dimension minus one, after clamping the register into 1..MAX_DIM
	function automatic logic [IW-1:0] dim_m1(input logic [CW-1:0] r);
		logic [IW-1:0] d;
		if (r == '0) begin
			d = '0;
		end else if (r > CW'(MAX_DIM)) begin
			d = IW'(MAX_DIM - 1);
		end else begin
			d = IW'(r - CW'(1));
		end
		return d;
	endfunction

	// configuration registers
	logic [CW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

	// sequencer
	mamm_pkg::state_t state_q, state_d;
	logic [mamm_pkg::ACT_W-1:0] op_q, op_d;
	logic inv_q, inv_d;
	logic mat_q, mat_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [IW-1:0] pa_m1, qa_m1, pb_m1, qb_m1;
	logic [IW-1:0] ilim, jlim, klim;
	logic issue, acc_clr, load_out;

	// input fields
	logic [PW-1:0] in_row, in_col;
	logic signed [mamm_pkg::VAL_W-1:0] in_value;
	logic in_acc;
	logic ld_a, ld_b;
	logic [AW-1:0] ld_addr;

	// store read and shared arithmetic pipe
	logic signed [EW-1:0] mem_a [DEPTH];
	logic signed [EW-1:0] mem_b [DEPTH];
	logic [AW-1:0] addr_a, addr_b;
	logic [IW-1:0] a_col, b_row;
	logic rv_s1, uv_s2;
	logic first_s1;
	logic signed [EW-1:0] rd_a_s1, rd_b_s1, mm_val;
	logic signed [2*EW-1:0] prod_w;
	logic signed [RW-1:0] unit_s2;
	logic signed [RW-1:0] acc_q;
	logic signed [EW-1:0] mn_q, mx_q;

	// output register
	logic out_valid_q;
	logic [mamm_pkg::KIND_W-1:0] out_kind_q, kind_d;
	logic [PW-1:0] out_row_q, out_col_q, row_d, col_d;
	logic signed [RW-1:0] out_res_q, res_d;
	logic signed [SW-1:0] out_sec_q, sec_d;
	logic out_last_q, last_d;
	logic elem_last;

	// Unpack ports
	assign cfg_ready     = 1'b1;
	assign in_row        = s_axis_tdata[2:0];
	assign in_col        = s_axis_tdata[5:3];
	assign in_value      = s_axis_tdata[21:6];
	assign s_axis_tready = (state_q == mamm_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign ld_addr       = AW'(in_row * MAX_DIM + in_col);
	assign ld_a = in_acc && (s_axis_tuser == mamm_pkg::ACT_LOAD_A)
		&& (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
	assign ld_b = in_acc && (s_axis_tuser == mamm_pkg::ACT_LOAD_B)
		&& (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_sec_q, out_res_q, out_col_q, out_row_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CW'(1);
			cols_a_q <= CW'(1);
			rows_b_q <= CW'(1);
			cols_b_q <= CW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mamm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data;
				mamm_pkg::CFG_COLS_A: cols_a_q <= cfg_data;
				mamm_pkg::CFG_ROWS_B: rows_b_q <= cfg_data;
				mamm_pkg::CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pa_m1 = dim_m1(rows_a_q);
	assign qa_m1 = dim_m1(cols_a_q);
	assign pb_m1 = dim_m1(rows_b_q);
	assign qb_m1 = dim_m1(cols_b_q);

	// Loop bounds for the running command
	always_comb begin
		ilim = pa_m1;
		jlim = qa_m1;
		klim = '0;
		case (op_q)
			mamm_pkg::ACT_PROD: begin
				jlim = qb_m1;
				klim = qa_m1;
			end
			mamm_pkg::ACT_MINMAX: begin
				ilim = mat_q ? pb_m1 : pa_m1;
				jlim = mat_q ? qb_m1 : qa_m1;
			end
			default: ;
		endcase
	end

	assign elem_last = (i_q == ilim) && (j_q == jlim);

	// Store addresses: product walks row i of A and column j of B
	assign a_col  = (op_q == mamm_pkg::ACT_PROD) ? k_q : j_q;
	assign b_row  = (op_q == mamm_pkg::ACT_PROD) ? k_q : i_q;
	assign addr_a = AW'(i_q * MAX_DIM + a_col);
	assign addr_b = AW'(b_row * MAX_DIM + j_q);

	// Result fields presented while emitting
	always_comb begin
		kind_d = mamm_pkg::KIND_SUM;
		row_d  = PW'(i_q);
		col_d  = PW'(j_q);
		res_d  = acc_q;
		sec_d  = '0;
		last_d = elem_last;
		if (inv_q) begin
			kind_d = mamm_pkg::KIND_INVALID;
			row_d  = '0;
			col_d  = '0;
			res_d  = '0;
			last_d = 1'b1;
		end else begin
			case (op_q)
				mamm_pkg::ACT_PROD: kind_d = mamm_pkg::KIND_PROD;
				mamm_pkg::ACT_MINMAX: begin
					kind_d = mat_q ? mamm_pkg::KIND_MM_B : mamm_pkg::KIND_MM_A;
					row_d  = '0;
					col_d  = '0;
					res_d  = RW'(mn_q);
					sec_d  = SW'(mx_q);
					last_d = mat_q;
				end
				default: ;
			endcase
		end
	end

	// Next state and sequencer controls
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		inv_d    = inv_q;
		mat_d    = mat_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		issue    = 1'b0;
		acc_clr  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			mamm_pkg::ST_IDLE: begin
				if (in_acc && (s_axis_tuser == mamm_pkg::ACT_SUM
						|| s_axis_tuser == mamm_pkg::ACT_PROD
						|| s_axis_tuser == mamm_pkg::ACT_MINMAX)) begin
					op_d    = s_axis_tuser;
					mat_d   = 1'b0;
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
					acc_clr = 1'b1;
					inv_d   = 1'b0;
					if (s_axis_tuser == mamm_pkg::ACT_SUM) begin
						inv_d = (pa_m1 != pb_m1) || (qa_m1 != qb_m1);
					end else if (s_axis_tuser == mamm_pkg::ACT_PROD) begin
						inv_d = (qa_m1 != pb_m1);
					end
					state_d = inv_d ? mamm_pkg::ST_EMIT : mamm_pkg::ST_RUN;
				end
			end
			mamm_pkg::ST_RUN: begin
				// issue one store read per cycle
				issue = 1'b1;
				if (op_q == mamm_pkg::ACT_MINMAX) begin
					if (j_q == jlim) begin
						if (i_q == ilim) begin
							state_d = mamm_pkg::ST_DRAIN;
						end else begin
							i_d = i_q + IW'(1);
							j_d = '0;
						end
					end else begin
						j_d = j_q + IW'(1);
					end
				end else if (k_q == klim) begin
					state_d = mamm_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + IW'(1);
				end
			end
			mamm_pkg::ST_DRAIN: begin
				if (!rv_s1 && !uv_s2) begin
					state_d = mamm_pkg::ST_EMIT;
				end
			end
			mamm_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					if (inv_q || last_d) begin
						state_d = mamm_pkg::ST_IDLE;
					end else if (op_q == mamm_pkg::ACT_MINMAX) begin
						// move on to matrix B
						mat_d   = 1'b1;
						i_d     = '0;
						j_d     = '0;
						state_d = mamm_pkg::ST_RUN;
					end else begin
						acc_clr = 1'b1;
						k_d     = '0;
						if (j_q == jlim) begin
							i_d = i_q + IW'(1);
							j_d = '0;
						end else begin
							j_d = j_q + IW'(1);
						end
						state_d = mamm_pkg::ST_RUN;
					end
				end
			end
			default: state_d = mamm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer and pipe control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mamm_pkg::ST_IDLE;
			op_q        <= mamm_pkg::ACT_SUM;
			inv_q       <= 1'b0;
			mat_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rv_s1       <= 1'b0;
			uv_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			inv_q   <= inv_d;
			mat_q   <= mat_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			rv_s1   <= issue;
			uv_s2   <= rv_s1 && (op_q != mamm_pkg::ACT_MINMAX);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Element stores: one write port, registered read
	always_ff @(posedge clk) begin
		if (ld_a) begin
			mem_a[ld_addr] <= EW'(in_value);
		end
		if (ld_b) begin
			mem_b[ld_addr] <= EW'(in_value);
		end
		rd_a_s1  <= mem_a[addr_a];
		rd_b_s1  <= mem_b[addr_b];
		first_s1 <= (i_q == '0) && (j_q == '0);
	end

	// Shared unit: multiply for products, add for sums, compare for min/max
	assign prod_w = rd_a_s1 * rd_b_s1;
	assign mm_val = mat_q ? rd_b_s1 : rd_a_s1;

	always_ff @(posedge clk) begin
		if (op_q == mamm_pkg::ACT_PROD) begin
			unit_s2 <= RW'(prod_w);
		end else begin
			unit_s2 <= RW'(rd_a_s1) + RW'(rd_b_s1);
		end
		if (rv_s1 && (op_q == mamm_pkg::ACT_MINMAX)) begin
			if (first_s1 || mm_val < mn_q) begin
				mn_q <= mm_val;
			end
			if (first_s1 || mm_val > mx_q) begin
				mx_q <= mm_val;
			end
		end
		// accumulate one term per cycle
		if (acc_clr) begin
			acc_q <= '0;
		end else if (uv_s2) begin
			acc_q <= acc_q + unit_s2;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= kind_d;
			out_row_q  <= row_d;
			out_col_q  <= col_d;
			out_res_q  <= res_d;
			out_sec_q  <= sec_d;
			out_last_q <= last_d;
		end
	end

	// The unit only takes a transaction with the arithmetic pipe empty
	a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!rv_s1 && !uv_s2))
		else $error("input ready while arithmetic pipe busy");

	// An accumulate step always follows a store read in the cycle before
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		uv_s2 |-> $past(rv_s1))
		else $error("accumulate without preceding read");

	// Min/max of A is never the final result of a run
	a_mm_a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == mamm_pkg::KIND_MM_A) |-> !m_axis_tlast)
		else $error("min/max of A marked last");

	// Invalid-order results carry zero payload and close the run
	a_invalid_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == mamm_pkg::KIND_INVALID)
		|-> (m_axis_tlast && m_axis_tdata == '0))
		else $error("malformed invalid-order result");

endmodule
